// ----- hw/rtl/dlpom_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual low-pulse occupancy meter: shared definitions
// Field widths, register indexes and output limits used by the result
// and configuration interfaces and the meter.
// ----------------------------------------------------------------------------
`default_nettype none

package dlpom_pkg;

  // Register file
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 32;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_WINDOW_TICKS = 1'b0,
    CFG_SCALE_Q32    = 1'b1
  } cfg_index_t;

  localparam int WIN_WIDTH   = 26;
  localparam int SCALE_WIDTH = 32;

  localparam logic [WIN_WIDTH-1:0]   WINDOW_RESET = 26'd30000000;
  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET  = 32'd8812557;

  // Result fields, unsigned Q16.8
  localparam int OUT_WIDTH = 24;

  // Product is shifted down by this many bits (Q0.32 scale into Q16.8)
  localparam int PROD_SHIFT = 24;

endpackage

`default_nettype wire

// ----- hw/rtl/dlpom_tick_if.sv -----
// ----------------------------------------------------------------------------
// Sample tick channel
// One transaction per microsecond tick: sampled levels of both pulse pins.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlpom_tick_if;

  logic valid;
  logic ready;
  logic level_pm10;
  logic level_pm25;

  modport source (output valid, output level_pm10, output level_pm25, input ready);
  modport sink   (input valid, input level_pm10, input level_pm25, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/dlpom_result_if.sv -----
// ----------------------------------------------------------------------------
// Concentration result channel
// One transaction per analysis window: both channel concentrations in Q16.8.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlpom_result_if import dlpom_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [OUT_WIDTH-1:0] conc_pm10_q8;
  logic [OUT_WIDTH-1:0] conc_pm25_q8;

  modport source (output valid, output conc_pm10_q8, output conc_pm25_q8, input ready);
  modport sink   (input valid, input conc_pm10_q8, input conc_pm25_q8, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/dlpom_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// One transaction writes one register: index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlpom_cfg_if import dlpom_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/dual_low_pulse_occupancy_meter_unit.sv -----
// ----------------------------------------------------------------------------
// Dual low-pulse occupancy meter
// Measures low-pulse occupancy of two dust-sensor pulse pins over a window
// and reports a scaled concentration for each at every window end.
// ----------------------------------------------------------------------------
//
// Usage:
//   samples : one transaction per microsecond tick with both pin levels.
//   results : one transaction at each window end, conc_pm10_q8/conc_pm25_q8
//             = floor(low_total * scale_q32 / 2^24), saturated to 24 bits.
//   cfg     : index 0 = window_ticks, index 1 = scale_q32; write only while
//             the meter is idle. cfg.ready is high whenever out of reset.
// Throughput / pipeline:
//   A tick is taken every cycle while samples.ready is high. Edge detection,
//   counters and the window check update in the cycle of the transaction.
//   A window-ending tick's result reaches results through the total capture
//   register (loaded at its accepting edge), partial-product register (two
//   16-bit slices of the scale per channel), then the sum/saturate output.
// Reset (rst, synchronous): counters and totals clear, both channels are
//   disarmed with last level high, registers return to their defaults.
//   samples.ready and cfg.ready are low while rst is high.
// Stall: while results is held off, up to three window results stay in the
//   pipeline; samples.ready drops only when a stalled result still sits in
//   the capture register.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_low_pulse_occupancy_meter_unit import dlpom_pkg::*; #(
  parameter int COUNT_WIDTH = 26
) (
  input  wire logic     clk,
  input  wire logic     rst,
  dlpom_tick_if.sink    samples,
  dlpom_result_if.source results,
  dlpom_cfg_if.sink     cfg
);

  localparam int CW     = COUNT_WIDTH;
  localparam int CMP_W  = COUNT_WIDTH + WIN_WIDTH;
  localparam int HALF_W = SCALE_WIDTH / 2;
  localparam int PP_W   = COUNT_WIDTH + HALF_W;
  localparam int SUM_W  = COUNT_WIDTH + SCALE_WIDTH + 1;
  localparam int Q_W    = SUM_W - PROD_SHIFT;

  typedef struct packed {
    logic          last;
    logic          armed;
    logic [CW-1:0] open;
    logic [CW-1:0] total;
  } chan_t;

  // Per-channel edge handling for one tick
  function automatic chan_t chan_step(input logic lvl, input chan_t cur);
    chan_t         nxt;
    logic [CW:0]   sum;
    nxt = cur;
    sum = {1'b0, cur.total} + {1'b0, cur.open};
    if (!lvl) begin
      if (cur.last) begin
        nxt.armed = 1'b1;
        nxt.open  = CW'(1);
      end else if (cur.armed) begin
        nxt.open = (cur.open == '1) ? cur.open : cur.open + CW'(1);
      end
    end else if (!cur.last && cur.armed) begin
      nxt.total = sum[CW] ? '1 : sum[CW-1:0];
      nxt.armed = 1'b0;
      nxt.open  = '0;
    end
    nxt.last = lvl;
    return nxt;
  endfunction

  // Registers
  logic [WIN_WIDTH-1:0]   window_ticks;
  logic [SCALE_WIDTH-1:0] scale_q32;
  chan_t                  ch10, ch25;
  logic [CW-1:0]          tick_count;

  // Pipeline
  logic          a_valid;
  logic [CW-1:0] a_tot10, a_tot25;
  logic          b_valid;
  logic [PP_W-1:0] b_lo10, b_hi10, b_lo25, b_hi25;
  logic          c_valid;
  logic [OUT_WIDTH-1:0] c_conc10, c_conc25;

  // Flow control
  logic c_free, b_free, a_free, b_move, a_move;
  logic in_acc, cfg_acc;

  assign c_free = !c_valid || results.ready;
  assign b_move = b_valid && c_free;
  assign b_free = !b_valid || c_free;
  assign a_move = a_valid && b_free;
  assign a_free = !a_valid || b_free;

  assign samples.ready = a_free && !rst;
  assign cfg.ready     = !rst;
  assign in_acc        = samples.valid && samples.ready;
  assign cfg_acc       = cfg.valid && cfg.ready;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
      scale_q32    <= SCALE_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_WINDOW_TICKS: window_ticks <= cfg.data[WIN_WIDTH-1:0];
        CFG_SCALE_Q32:    scale_q32    <= cfg.data[SCALE_WIDTH-1:0];
      endcase
    end
  end

  // Tick logic: edges, counters, window end
  chan_t           ch10_next, ch25_next;
  logic [CW:0]     tick_inc;
  logic [CMP_W-1:0] tick_inc_ext, window_ext;
  logic            win_end;

  always_comb begin
    ch10_next    = chan_step(samples.level_pm10, ch10);
    ch25_next    = chan_step(samples.level_pm25, ch25);
    tick_inc     = {1'b0, tick_count} + (CW+1)'(1);
    tick_inc_ext = CMP_W'(tick_inc);
    window_ext   = CMP_W'(window_ticks);
    win_end      = (tick_inc_ext >= window_ext) || (tick_count == '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch10       <= '{last: 1'b1, armed: 1'b0, open: '0, total: '0};
      ch25       <= '{last: 1'b1, armed: 1'b0, open: '0, total: '0};
      tick_count <= '0;
    end else if (in_acc) begin
      if (win_end) begin
        ch10       <= '{last: samples.level_pm10, armed: 1'b0, open: '0, total: '0};
        ch25       <= '{last: samples.level_pm25, armed: 1'b0, open: '0, total: '0};
        tick_count <= '0;
      end else begin
        ch10       <= ch10_next;
        ch25       <= ch25_next;
        tick_count <= tick_inc[CW-1:0];
      end
    end
  end

  // Stage A: capture totals at window end
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_acc && win_end;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_acc && win_end) begin
      a_tot10 <= ch10_next.total;
      a_tot25 <= ch25_next.total;
    end
  end

  // Stage B: partial products against the two scale halves
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_move;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_lo10 <= PP_W'(a_tot10) * PP_W'(scale_q32[HALF_W-1:0]);
      b_hi10 <= PP_W'(a_tot10) * PP_W'(scale_q32[SCALE_WIDTH-1:HALF_W]);
      b_lo25 <= PP_W'(a_tot25) * PP_W'(scale_q32[HALF_W-1:0]);
      b_hi25 <= PP_W'(a_tot25) * PP_W'(scale_q32[SCALE_WIDTH-1:HALF_W]);
    end
  end

  // Stage C: combine, shift down to Q16.8, saturate
  logic [SUM_W-1:0] sum10, sum25;
  logic [Q_W-1:0]   q10, q25;
  logic [OUT_WIDTH-1:0] sat10, sat25;

  always_comb begin
    sum10 = SUM_W'({b_hi10, HALF_W'(0)}) + SUM_W'(b_lo10);
    sum25 = SUM_W'({b_hi25, HALF_W'(0)}) + SUM_W'(b_lo25);
    q10   = sum10[SUM_W-1:PROD_SHIFT];
    q25   = sum25[SUM_W-1:PROD_SHIFT];
    sat10 = (|q10[Q_W-1:OUT_WIDTH]) ? '1 : q10[OUT_WIDTH-1:0];
    sat25 = (|q25[Q_W-1:OUT_WIDTH]) ? '1 : q25[OUT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_move;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_conc10 <= sat10;
      c_conc25 <= sat25;
    end
  end

  assign results.valid        = c_valid;
  assign results.conc_pm10_q8 = c_conc10;
  assign results.conc_pm25_q8 = c_conc25;

  // Assertions
  a_window_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && win_end) |=> (tick_count == '0 && !ch10.armed && !ch25.armed))
    else $error("window end did not clear counter and arming");

  a_open_needs_arm: assert property (@(posedge clk) disable iff (rst)
    (ch10.armed || ch10.open == '0) && (ch25.armed || ch25.open == '0))
    else $error("open pulse count held while disarmed");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (a_valid && b_valid && c_valid && !results.ready))
    else $error("tick channel stalled with free pipeline room");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(c_valid) |-> $past(b_valid))
    else $error("result appeared without a product in flight");

endmodule

`default_nettype wire
